[hdl/fitness_trainer_page_engine_assert.svh]
// ----------------------------------------------------------------------------
// Fitness trainer page engine assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef FITNESS_TRAINER_PAGE_ENGINE_ASSERT_SVH
`define FITNESS_TRAINER_PAGE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define FTPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FTPE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FTPE_ASSERT(lbl, prop, msg)
`define FTPE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hdl/ftpe_pkg.sv]
// ----------------------------------------------------------------------------
// Fitness trainer page engine package
// Shared types, command codes, page numbers and divide constants.
// ----------------------------------------------------------------------------
package ftpe_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SLOT = 2'd1,
    CMD_RX   = 2'd2
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_CHANNEL  = 1'b0,
    CFG_FE_STATE = 1'b1
  } cfg_idx_e;

  localparam logic [3:0] FeStateReset = 4'd2;
  localparam int unsigned PatternLen = 64;

  localparam logic [7:0] PAGE_GENERAL  = 8'h10;
  localparam logic [7:0] PAGE_TRAINER  = 8'h19;
  localparam logic [7:0] PAGE_SETTINGS = 8'h11;
  localparam logic [7:0] PAGE_CAPS     = 8'h36;
  localparam logic [7:0] PAGE_MANUF    = 8'h50;
  localparam logic [7:0] PAGE_PRODUCT  = 8'h51;
  localparam logic [7:0] PAGE_TARGET   = 8'h31;
  localparam logic [7:0] PAGE_TRACK    = 8'h33;
  localparam logic [7:0] PAGE_REQUEST  = 8'h46;
  localparam logic [7:0] REQ_CMD_TYPE  = 8'd1;
  localparam logic [7:0] CAPS_BYTE     = 8'b00000110;
  localparam logic [7:0] DEVICE_TYPE   = 8'h19;

  // x / 100 == (x * 83887) >> 23 for any 16-bit x
  localparam logic [16:0] GradeRecip  = 17'd83887;
  localparam int unsigned GradeShift  = 23;
  localparam logic [9:0]  GradeOffset = 10'd200;
  // t / 700 == (t * 1498) >> 20 for any 14-bit t
  localparam logic [10:0] TgtRecip    = 11'd1498;
  localparam int unsigned TgtShift    = 20;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        rx_channel;
    logic [7:0]        page;
    logic [7:0]        b6;
    logic [7:0]        b7;
    logic [13:0]       target_cand;
    logic signed [9:0] grade_cand;
    logic [15:0]       cur_power;
    logic [7:0]        cadence;
  } ftpe_item_t;

endpackage

[hdl/fitness_trainer_page_engine.sv]
// Pipeline: an item is registered in the input stage, then processed into the
// result register once the result register is free or not stalled.
// Throughput: one item per cycle, limited only by the result register stall.
// Items that cause no result (ticks, ignored pages) still wait for a free result register.
// Reset: asynchronous, active low; clears profile state and config to defaults.
// ----------------------------------------------------------------------------
// Fitness trainer page engine
// Broadcast page rotation and setpoint handling for a trainer profile.
// ----------------------------------------------------------------------------
`include "fitness_trainer_page_engine_assert.svh"

module fitness_trainer_page_engine
  import ftpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        rx_channel_i,
  input  logic [7:0]        rx_b0_i,
  input  logic [7:0]        rx_b1_i,
  input  logic [7:0]        rx_b2_i,
  input  logic [7:0]        rx_b3_i,
  input  logic [7:0]        rx_b4_i,
  input  logic [7:0]        rx_b5_i,
  input  logic [7:0]        rx_b6_i,
  input  logic [7:0]        rx_b7_i,
  input  logic [15:0]       cur_power_i,
  input  logic [7:0]        cadence_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              send_payload_o,
  output logic [7:0]        tx_b0_o,
  output logic [7:0]        tx_b1_o,
  output logic [7:0]        tx_b2_o,
  output logic [7:0]        tx_b3_o,
  output logic [7:0]        tx_b4_o,
  output logic [7:0]        tx_b5_o,
  output logic [7:0]        tx_b6_o,
  output logic [7:0]        tx_b7_o,
  output logic [13:0]       target_power_o,
  output logic signed [9:0] grade_o
);

  logic       item_valid;
  logic       take;
  ftpe_item_t item;

  ftpe_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .rx_channel_i (rx_channel_i),
    .rx_b0_i      (rx_b0_i),
    .rx_b5_i      (rx_b5_i),
    .rx_b6_i      (rx_b6_i),
    .rx_b7_i      (rx_b7_i),
    .cur_power_i  (cur_power_i),
    .cadence_i    (cadence_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ftpe_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .send_payload_o (send_payload_o),
    .tx_b0_o        (tx_b0_o),
    .tx_b1_o        (tx_b1_o),
    .tx_b2_o        (tx_b2_o),
    .tx_b3_o        (tx_b3_o),
    .tx_b4_o        (tx_b4_o),
    .tx_b5_o        (tx_b5_o),
    .tx_b6_o        (tx_b6_o),
    .tx_b7_o        (tx_b7_o),
    .target_power_o (target_power_o),
    .grade_o        (grade_o)
  );

  `FTPE_ASSERT_RST(a_reset_no_result, !rst_ni |-> !out_valid_o, "result valid in reset")
  `FTPE_ASSERT(a_grade_range,
               out_valid_o |-> (grade_o >= -10'sd200 && grade_o <= 10'sd455),
               "grade out of range")
  `FTPE_ASSERT(a_update_zero,
               (out_valid_o && !send_payload_o) |->
                 (tx_b0_o == 8'd0 && tx_b7_o == 8'd0 && tx_b3_o == 8'd0),
               "update report carries page bytes")
  `FTPE_ASSERT(a_level_range,
               (out_valid_o && send_payload_o && tx_b0_o == PAGE_SETTINGS) |->
                 (tx_b6_o <= 8'd23),
               "target level out of range")

endmodule

[hdl/ftpe_in_stage.sv]
// ----------------------------------------------------------------------------
// Fitness trainer page engine input stage
// Input register with setpoint pre-decode (target scale, grade divide).
// ----------------------------------------------------------------------------
module ftpe_in_stage
  import ftpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        rx_channel_i,
  input  logic [7:0]        rx_b0_i,
  input  logic [7:0]        rx_b5_i,
  input  logic [7:0]        rx_b6_i,
  input  logic [7:0]        rx_b7_i,
  input  logic [15:0]       cur_power_i,
  input  logic [7:0]        cadence_i,
  input  logic              take_i,
  output logic              item_valid_o,
  output ftpe_item_t        item_o
);

  logic        valid_q;
  ftpe_item_t  item_d, item_q;
  logic [32:0] grade_prod;
  logic [9:0]  grade_quot;

  assign grade_prod = {rx_b6_i, rx_b5_i} * GradeRecip;
  assign grade_quot = grade_prod[GradeShift +: 10];

  always_comb begin
    item_d             = item_q;
    item_d.cmd         = cmd_i;
    item_d.rx_channel  = rx_channel_i;
    item_d.page        = rx_b0_i;
    item_d.b6          = rx_b6_i;
    item_d.b7          = rx_b7_i;
    item_d.target_cand = {rx_b7_i, rx_b6_i[7:2]};
    item_d.grade_cand  = $signed(grade_quot - GradeOffset);
    item_d.cur_power   = cur_power_i;
    item_d.cadence     = cadence_i;
  end

  assign in_stall_o   = valid_q && !take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[hdl/ftpe_core.sv]
// ----------------------------------------------------------------------------
// Fitness trainer page engine core
// Profile state, page rotation, setpoint handling and result register.
// ----------------------------------------------------------------------------
module ftpe_core
  import ftpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              item_valid_i,
  input  ftpe_item_t        item_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              send_payload_o,
  output logic [7:0]        tx_b0_o,
  output logic [7:0]        tx_b1_o,
  output logic [7:0]        tx_b2_o,
  output logic [7:0]        tx_b3_o,
  output logic [7:0]        tx_b4_o,
  output logic [7:0]        tx_b5_o,
  output logic [7:0]        tx_b6_o,
  output logic [7:0]        tx_b7_o,
  output logic [13:0]       target_power_o,
  output logic signed [9:0] grade_o
);

  logic [7:0]        channel_q;
  logic [3:0]        fe_state_q;
  logic [7:0]        qs_q, qs_d;
  logic [6:0]        slot_q, slot_d;
  logic              repeat_q, repeat_d;
  logic              is81_q, is81_d;
  logic [7:0]        event_q, event_d;
  logic [15:0]       total_q, total_d;
  logic [13:0]       target_q, target_d;
  logic signed [9:0] grade_q, grade_d;

  logic              res_valid_q;
  logic              res_send_q;
  logic [7:0]        res_b_q [8];
  logic [13:0]       res_target_q;
  logic signed [9:0] res_grade_q;

  logic              has_res;
  logic              send_d;
  logic [7:0]        b_d [8];
  logic              slot_free;
  logic [7:0]        status;
  logic [24:0]       tgt_prod;
  logic [7:0]        tgt_level;
  logic [2:0]        phase;

  assign slot_free = !res_valid_q || !out_stall_i;
  assign take_o    = item_valid_i && slot_free;
  assign status    = {fe_state_q, 4'd0};
  assign tgt_prod  = target_q * TgtRecip;
  assign tgt_level = {3'd0, tgt_prod[TgtShift +: 5]};
  assign phase     = slot_q[2:0];

  always_comb begin
    qs_d     = qs_q;
    slot_d   = slot_q;
    repeat_d = repeat_q;
    is81_d   = is81_q;
    event_d  = event_q;
    total_d  = total_q;
    target_d = target_q;
    grade_d  = grade_q;
    has_res  = 1'b0;
    send_d   = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b_d[i] = 8'd0;
    end
    case (item_i.cmd)
      CMD_TICK: begin
        qs_d = qs_q + 8'd1;
      end
      CMD_SLOT: begin
        has_res = 1'b1;
        send_d  = 1'b1;
        if (slot_q < 7'(PatternLen)) begin
          slot_d = slot_q + 7'd1;
          case (phase) inside
            3'd2, 3'd6: begin
              total_d = total_q + item_i.cur_power;
              event_d = event_q + 8'd1;
              b_d[0]  = PAGE_TRAINER;
              b_d[1]  = event_q;
              b_d[2]  = item_i.cadence;
              b_d[3]  = total_d[7:0];
              b_d[4]  = total_d[15:8];
              b_d[5]  = item_i.cur_power[7:0];
              b_d[6]  = item_i.cur_power[15:8];
            end
            3'd3, 3'd7: begin
              b_d[0] = PAGE_SETTINGS;
              b_d[1] = 8'hFF;
              b_d[2] = 8'hFF;
              b_d[3] = 8'hFF;
              b_d[4] = 8'hFF;
              b_d[5] = 8'h7F;
              b_d[6] = tgt_level;
              b_d[7] = status;
            end
            default: begin
              b_d[0] = PAGE_GENERAL;
              b_d[1] = DEVICE_TYPE;
              b_d[2] = qs_q;
              b_d[3] = 8'hFF;
              b_d[6] = 8'hFF;
              b_d[7] = status;
            end
          endcase
        end else begin
          b_d[1] = 8'hFF;
          b_d[2] = 8'hFF;
          b_d[3] = 8'h01;
          b_d[4] = 8'hFF;
          if (is81_q) begin
            b_d[0] = PAGE_PRODUCT;
            b_d[5] = 8'hFF;
            b_d[6] = 8'hFF;
            b_d[7] = 8'hFF;
          end else begin
            b_d[0] = PAGE_MANUF;
            b_d[6] = 8'h01;
          end
          if (repeat_q) begin
            is81_d   = !is81_q;
            repeat_d = 1'b0;
            slot_d   = 7'd0;
          end else begin
            repeat_d = 1'b1;
          end
        end
      end
      CMD_RX: begin
        if (item_i.rx_channel == channel_q) begin
          case (item_i.page)
            PAGE_TARGET: begin
              if (item_i.target_cand != target_q) begin
                target_d = item_i.target_cand;
                has_res  = 1'b1;
              end
            end
            PAGE_TRACK: begin
              if (item_i.grade_cand != grade_q) begin
                grade_d = item_i.grade_cand;
                has_res = 1'b1;
              end
            end
            PAGE_REQUEST: begin
              if (item_i.b7 == REQ_CMD_TYPE && item_i.b6 == PAGE_CAPS) begin
                has_res = 1'b1;
                send_d  = 1'b1;
                b_d[0]  = PAGE_CAPS;
                for (int i = 1; i < 7; i++) begin
                  b_d[i] = 8'hFF;
                end
                b_d[7] = CAPS_BYTE;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q  <= 8'd0;
      fe_state_q <= FeStateReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANNEL:  channel_q  <= cfg_wdata_i;
        CFG_FE_STATE: fe_state_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_q     <= 8'd0;
      slot_q   <= 7'd0;
      repeat_q <= 1'b0;
      is81_q   <= 1'b0;
      event_q  <= 8'd0;
      total_q  <= 16'd0;
      target_q <= 14'd0;
      grade_q  <= 10'sd0;
    end else if (take_o) begin
      qs_q     <= qs_d;
      slot_q   <= slot_d;
      repeat_q <= repeat_d;
      is81_q   <= is81_d;
      event_q  <= event_d;
      total_q  <= total_d;
      target_q <= target_d;
      grade_q  <= grade_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (slot_free) begin
      res_valid_q <= take_o && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && has_res) begin
      res_send_q   <= send_d;
      res_b_q      <= b_d;
      res_target_q <= target_d;
      res_grade_q  <= grade_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign send_payload_o = res_send_q;
  assign tx_b0_o        = res_b_q[0];
  assign tx_b1_o        = res_b_q[1];
  assign tx_b2_o        = res_b_q[2];
  assign tx_b3_o        = res_b_q[3];
  assign tx_b4_o        = res_b_q[4];
  assign tx_b5_o        = res_b_q[5];
  assign tx_b6_o        = res_b_q[6];
  assign tx_b7_o        = res_b_q[7];
  assign target_power_o = res_target_q;
  assign grade_o        = res_grade_q;

endmodule

[tb/sv/fitness_trainer_page_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fitness trainer page engine testbench
// Drives ticks, transmit slots and received pages through the valid/stall
// input, predicts every broadcast page and setpoint update, and checks each
// result field by field under random bursts, receiver stalls and register
// changes between phases.
// ----------------------------------------------------------------------------
module fitness_trainer_page_engine_tb;
  import ftpe_pkg::*;

  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam int         PhaseItems  = 267;
  localparam int         SettleCycles = 8;
  localparam int         HoldCycles  = 200;
  localparam int         MaxPrinted  = 40;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [7:0]      rx_channel;
    logic [7:0][7:0] rx;
    logic [15:0]     cur_power;
    logic [7:0]      cadence;
  } item_t;

  typedef struct packed {
    logic              send;
    logic [7:0][7:0]   tx;
    logic [13:0]       target;
    logic signed [9:0] grade;
  } page_t;

  typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_DRAIN, ENT_HOLD} entry_e;

  typedef struct {
    entry_e     kind;
    item_t      item;
    cfg_idx_e   idx;
    logic [7:0] data;
  } entry_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  item_t drv = '0;
  logic send_payload_o;
  logic [7:0] tx_b0_o, tx_b1_o, tx_b2_o, tx_b3_o, tx_b4_o, tx_b5_o, tx_b6_o, tx_b7_o;
  logic [13:0] target_power_o;
  logic signed [9:0] grade_o;

  fitness_trainer_page_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (drv.cmd),
    .rx_channel_i   (drv.rx_channel),
    .rx_b0_i        (drv.rx[0]),
    .rx_b1_i        (drv.rx[1]),
    .rx_b2_i        (drv.rx[2]),
    .rx_b3_i        (drv.rx[3]),
    .rx_b4_i        (drv.rx[4]),
    .rx_b5_i        (drv.rx[5]),
    .rx_b6_i        (drv.rx[6]),
    .rx_b7_i        (drv.rx[7]),
    .cur_power_i    (drv.cur_power),
    .cadence_i      (drv.cadence),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .send_payload_o (send_payload_o),
    .tx_b0_o        (tx_b0_o),
    .tx_b1_o        (tx_b1_o),
    .tx_b2_o        (tx_b2_o),
    .tx_b3_o        (tx_b3_o),
    .tx_b4_o        (tx_b4_o),
    .tx_b5_o        (tx_b5_o),
    .tx_b6_o        (tx_b6_o),
    .tx_b7_o        (tx_b7_o),
    .target_power_o (target_power_o),
    .grade_o        (grade_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // trainer state as the block should hold it
  logic [7:0]        chan_sel = 8'd0;
  logic [3:0]        fe_mode = FeStateReset;
  logic [7:0]        elapsed_qs = '0;
  logic [6:0]        slot_idx = '0;
  logic              common_second = 1'b0;
  logic              common_81 = 1'b0;
  logic [7:0]        trainer_events = '0;
  logic [15:0]       power_sum = '0;
  logic [13:0]       target_now = '0;
  logic signed [9:0] grade_now = '0;

  entry_t event_q[$];
  page_t  due_pages[$];

  int fault_count = 0;
  int results_checked = 0;
  int items_driven = 0;
  int tick_count = 0;
  int slot_count = 0;
  int rx_count = 0;
  int common_pages = 0;
  int caps_replies = 0;
  int setpoint_updates = 0;
  int config_writes = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  logic stim_done = 1'b0;

  task automatic flag_error(input string msg);
    fault_count++;
    if (fault_count <= MaxPrinted) $display("[tb] %0t ns: %s", $time, msg);
  endtask

  function automatic void trainer_step(input item_t it);
    page_t       res;
    logic        produced;
    logic [2:0]  phase;
    logic [15:0] raw;
    logic [13:0] tgt_new;
    logic [13:0] tgt_div;
    logic signed [9:0] grade_new;
    logic [7:0]  status;
    res = '0;
    produced = 1'b0;
    status = {fe_mode, 4'h0};
    case (it.cmd)
      CMD_TICK: elapsed_qs = elapsed_qs + 8'd1;
      CMD_SLOT: begin
        produced = 1'b1;
        res.send = 1'b1;
        if (slot_idx < PatternLen) begin
          phase = slot_idx[2:0];
          slot_idx = slot_idx + 7'd1;
          if (phase == 3'd2 || phase == 3'd6) begin
            power_sum = power_sum + it.cur_power;
            res.tx = {8'h00, it.cur_power[15:8], it.cur_power[7:0], power_sum[15:8],
                      power_sum[7:0], it.cadence, trainer_events, PAGE_TRAINER};
            trainer_events = trainer_events + 8'd1;
          end else if (phase == 3'd3 || phase == 3'd7) begin
            tgt_div = target_now / 14'd700;
            res.tx = {status, tgt_div[7:0], 8'h7F, 32'hFFFF_FFFF, PAGE_SETTINGS};
          end else begin
            res.tx = {status, 8'hFF, 16'h0000, 8'hFF, elapsed_qs, DEVICE_TYPE,
                      PAGE_GENERAL};
          end
        end else begin
          common_pages++;
          if (common_81) res.tx = {32'hFFFF_FFFF, 8'h01, 16'hFFFF, PAGE_PRODUCT};
          else res.tx = {8'h00, 8'h01, 8'h00, 8'hFF, 8'h01, 16'hFFFF, PAGE_MANUF};
          if (common_second) begin
            common_81 = ~common_81;
            common_second = 1'b0;
            slot_idx = '0;
          end else begin
            common_second = 1'b1;
          end
        end
      end
      CMD_RX: begin
        if (it.rx_channel == chan_sel) begin
          if (it.rx[0] == PAGE_TARGET) begin
            raw = {it.rx[7], it.rx[6]};
            tgt_new = raw[15:2];
            if (tgt_new != target_now) begin
              target_now = tgt_new;
              produced = 1'b1;
              setpoint_updates++;
            end
          end else if (it.rx[0] == PAGE_TRACK) begin
            raw = {it.rx[6], it.rx[5]};
            grade_new = 10'(int'(raw / 16'd100) - 200);
            if (grade_new != grade_now) begin
              grade_now = grade_new;
              produced = 1'b1;
              setpoint_updates++;
            end
          end else if (it.rx[0] == PAGE_REQUEST && it.rx[7] == REQ_CMD_TYPE &&
                       it.rx[6] == PAGE_CAPS) begin
            produced = 1'b1;
            res.send = 1'b1;
            res.tx = {CAPS_BYTE, 48'hFFFF_FFFF_FFFF, PAGE_CAPS};
            caps_replies++;
          end
        end
      end
      default: ;
    endcase
    res.target = target_now;
    res.grade = grade_now;
    if (produced) due_pages.push_back(res);
  endfunction

  // driver: bursts of items, drain before register writes
  int   burst_left = 0;
  int   gap_left = 0;
  int   settle_left = 0;
  logic draining = 1'b0;

  always @(posedge clk_i) begin : driver
    logic   fire;
    logic   next_valid;
    logic   next_we;
    entry_t nxt;
    if (rst_ni) begin
      fire = in_valid_i && !in_stall_o;
      next_valid = in_valid_i && !fire;
      next_we = 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CHANNEL) chan_sel = cfg_wdata_i;
        else fe_mode = cfg_wdata_i[3:0];
        config_writes++;
      end
      if (fire) begin
        items_driven++;
        case (drv.cmd)
          CMD_TICK: tick_count++;
          CMD_SLOT: slot_count++;
          CMD_RX:   rx_count++;
          default: ;
        endcase
        trainer_step(drv);
      end
      if (!next_valid) begin
        if (draining) begin
          if (due_pages.size() != 0) settle_left = SettleCycles;
          else if (settle_left > 0) settle_left--;
          else draining = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (event_q.size() > 0) begin
          nxt = event_q.pop_front();
          case (nxt.kind)
            ENT_ITEM: begin
              drv <= nxt.item;
              next_valid = 1'b1;
              if (burst_left > 0) burst_left--;
              if (burst_left == 0) begin
                burst_left = $urandom_range(1, 48);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
              end
            end
            ENT_CFG: begin
              next_we = 1'b1;
              cfg_idx_i <= nxt.idx;
              cfg_wdata_i <= nxt.data;
            end
            ENT_DRAIN: begin
              draining = 1'b1;
              settle_left = SettleCycles;
            end
            default: hold_requests++;
          endcase
        end else if (!cfg_we_i) begin
          stim_done = 1'b1;
        end
      end
      in_valid_i <= next_valid;
      cfg_we_i <= next_we;
    end
  end

  // receiver: stall patterns plus long hold-offs on request
  int hold_left = 0;
  int mode_left = 0;
  int rx_mode = 0;

  always @(posedge clk_i) begin : receiver
    logic stall_n;
    if (hold_left > 0) begin
      hold_left--;
      stall_n = 1'b1;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
      stall_n = 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (rx_mode)
        0:       stall_n = 1'b0;
        1:       stall_n = ($urandom_range(0, 3) == 0);
        2:       stall_n = ($urandom_range(0, 3) != 0);
        default: stall_n = ~out_stall_i;
      endcase
    end
    out_stall_i <= stall_n;
  end

  always @(posedge clk_i) begin : monitor
    page_t got;
    page_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.send = send_payload_o;
      got.tx = {tx_b7_o, tx_b6_o, tx_b5_o, tx_b4_o, tx_b3_o, tx_b2_o, tx_b1_o, tx_b0_o};
      got.target = target_power_o;
      got.grade = grade_o;
      if (due_pages.size() == 0) begin
        flag_error($sformatf("unexpected result, page byte %02h", got.tx[0]));
      end else begin
        want = due_pages.pop_front();
        if (got.send !== want.send)
          flag_error($sformatf("result %0d send_payload %b, want %b",
                               results_checked, got.send, want.send));
        for (int k = 0; k < 8; k++)
          if (got.tx[k] !== want.tx[k])
            flag_error($sformatf("result %0d tx_b%0d %02h, want %02h",
                                 results_checked, k, got.tx[k], want.tx[k]));
        if (got.target !== want.target)
          flag_error($sformatf("result %0d target_power %0d, want %0d",
                               results_checked, got.target, want.target));
        if (got.grade !== want.grade)
          flag_error($sformatf("result %0d grade %0d, want %0d",
                               results_checked, got.grade, want.grade));
      end
      results_checked++;
    end
  end

  function automatic item_t make_item(input logic [1:0] cmd, input logic [7:0] chan,
                                      input logic [7:0] page, input logic [7:0] b7,
                                      input logic [7:0] b6, input logic [7:0] b5,
                                      input logic [15:0] pwr, input logic [7:0] cad);
    item_t it;
    it = '0;
    it.cmd = cmd;
    it.rx_channel = chan;
    it.rx[0] = page;
    it.rx[7] = b7;
    it.rx[6] = b6;
    it.rx[5] = b5;
    it.cur_power = pwr;
    it.cadence = cad;
    return it;
  endfunction

  function automatic item_t rand_item(input logic [7:0] chan);
    item_t it;
    int    sel;
    it.rx = {$urandom, $urandom};
    it.rx_channel = 8'($urandom);
    it.cur_power = 16'($urandom);
    it.cadence = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 14) it.cmd = CMD_TICK;
    else if (sel < 52) it.cmd = CMD_SLOT;
    else if (sel < 97) it.cmd = CMD_RX;
    else it.cmd = CmdUnused;
    if ($urandom_range(0, 9) < 8) it.rx_channel = chan;
    sel = $urandom_range(0, 9);
    if (sel < 4) it.rx[0] = PAGE_TARGET;
    else if (sel < 8) it.rx[0] = PAGE_TRACK;
    else if (sel < 9) begin
      it.rx[0] = PAGE_REQUEST;
      if ($urandom_range(0, 3) != 0) begin
        it.rx[7] = REQ_CMD_TYPE;
        it.rx[6] = PAGE_CAPS;
      end
    end
    // repeat the lowest setpoint so that unchanged values come up often
    if ($urandom_range(0, 6) == 0) begin
      it.rx[7] = 8'h00;
      it.rx[6] = 8'h00;
      it.rx[5] = 8'h00;
    end
    if ($urandom_range(0, 7) == 0) it.cur_power = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    entry_t e;
    e.kind = ENT_ITEM;
    e.item = it;
    e.idx = CFG_CHANNEL;
    e.data = '0;
    event_q.push_back(e);
  endtask

  task automatic queue_marker(input entry_e kind, input cfg_idx_e idx,
                              input logic [7:0] data);
    entry_t e;
    e.kind = kind;
    e.item = '0;
    e.idx = idx;
    e.data = data;
    event_q.push_back(e);
  endtask

  initial begin : stimulus
    logic [7:0] gen_chan;
    logic [7:0] state_data;
    gen_chan = 8'd0;
    queue_item(make_item(CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00));
    queue_item(make_item(CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00));
    queue_item(make_item(CMD_SLOT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 8'hFF));
    queue_item(make_item(CMD_SLOT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00));
    queue_item(make_item(CMD_SLOT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 8'hFF));
    queue_item(make_item(CMD_SLOT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00));
    queue_item(make_item(CMD_SLOT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00));
    queue_item(make_item(CMD_SLOT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00));
    // power of one wraps the running total to zero
    queue_item(make_item(CMD_SLOT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0001, 8'h00));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_TARGET, 8'hFF, 8'hFF, 8'h00, 16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_TARGET, 8'hFF, 8'hFF, 8'h00, 16'h0, 8'h0));
    queue_item(make_item(CMD_SLOT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_TARGET, 8'h00, 8'h00, 8'h00, 16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_TRACK, 8'h00, 8'hFF, 8'hFF, 16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_TRACK, 8'h00, 8'h00, 8'h00, 16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_TRACK, 8'h00, 8'h00, 8'h00, 16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_REQUEST, REQ_CMD_TYPE, PAGE_CAPS, 8'h00,
                         16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_REQUEST, 8'h00, PAGE_CAPS, 8'h00, 16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'd0, PAGE_REQUEST, REQ_CMD_TYPE, 8'h37, 8'h00,
                         16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'h80, PAGE_TARGET, 8'h12, 8'h34, 8'h00, 16'h0, 8'h0));
    queue_item(make_item(CMD_RX, 8'd0, 8'h20, 8'h12, 8'h34, 8'h56, 16'h0, 8'h0));
    queue_item(make_item(CmdUnused, 8'd0, PAGE_TARGET, 8'h12, 8'h34, 8'h00,
                         16'hFFFF, 8'hFF));
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin gen_chan = 8'hFF; state_data = 8'h0F; end
        1: begin gen_chan = 8'h00; state_data = 8'h00; end
        5: begin gen_chan = 8'h5A; state_data = 8'hF2; end
        default: begin gen_chan = 8'($urandom); state_data = 8'($urandom); end
      endcase
      queue_marker(ENT_DRAIN, CFG_CHANNEL, 8'h00);
      queue_marker(ENT_CFG, CFG_CHANNEL, gen_chan);
      queue_marker(ENT_CFG, CFG_FE_STATE, state_data);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == 120 && ph % 2 == 1) queue_marker(ENT_HOLD, CFG_CHANNEL, 8'h00);
        queue_item(rand_item(gen_chan));
      end
    end
  end

  initial begin : reset_seq
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : finish_seq
    wait (stim_done);
    while (due_pages.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("[tb] %0d items (%0d ticks, %0d slots, %0d received pages), %0d results checked",
             items_driven, tick_count, slot_count, rx_count, results_checked);
    $display("[tb] %0d common pages, %0d capability replies, %0d setpoint updates, %0d reg writes",
             common_pages, caps_replies, setpoint_updates, config_writes);
    if (fault_count == 0) begin
      $display("[fitness_trainer_page_engine] OK");
    end else begin
      $display("[fitness_trainer_page_engine] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("[fitness_trainer_page_engine] ERROR");
    $finish;
  end

endmodule

[fitness_trainer_page_engine.f]
+incdir+hdl
hdl/ftpe_pkg.sv
hdl/ftpe_in_stage.sv
hdl/ftpe_core.sv
hdl/fitness_trainer_page_engine.sv
tb/sv/fitness_trainer_page_engine_tb.sv
